// ===== rtl/crcrbs_pkg.sv =====
// shared types and constants for the bit-serial crc remainder block
`timescale 1ns / 1ps

package crcrbs_pkg;

  // largest supported generator degree, also the remainder register width
  localparam int MAX_DEGREE = 32;
  localparam int DEG_W      = 6;
  localparam int TOP_W      = $clog2(MAX_DEGREE);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE      = 2'd2;

  // crc_mode codes
  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_CHECK    = 1'b1;

  // reset values of the configuration registers
  localparam logic [MAX_DEGREE-1:0] GENERATOR_LOW_RESET = 32'd7;
  localparam logic [DEG_W-1:0]      POLY_DEGREE_RESET   = 6'd3;

  typedef struct packed {
    logic data_bit;
    logic frame_last;
  } in_item_t;

  typedef struct packed {
    logic [MAX_DEGREE-1:0] remainder_value;
    logic                  remainder_is_zero;
  } out_item_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [MAX_DEGREE-1:0] generator_low;
    logic [DEG_W-1:0]      poly_degree;
    logic                  crc_mode;
  } crc_cfg_t;

endpackage

// ===== rtl/crcrbs_step.sv =====
// one lfsr step of the remainder register for a single frame bit
`timescale 1ns / 1ps

module crcrbs_step (
  input  crcrbs_pkg::crc_cfg_t                cfg,
  input  logic [crcrbs_pkg::MAX_DEGREE-1:0]   remainder,
  input  logic                                data_bit,
  output logic [crcrbs_pkg::MAX_DEGREE-1:0]   remainder_next
);

  logic [crcrbs_pkg::DEG_W-1:0]      eff_degree;
  logic [crcrbs_pkg::MAX_DEGREE-1:0] mask;
  logic [crcrbs_pkg::MAX_DEGREE-1:0] low;
  logic [crcrbs_pkg::MAX_DEGREE-1:0] r_cur;
  logic [crcrbs_pkg::MAX_DEGREE-1:0] shifted;
  logic [crcrbs_pkg::TOP_W-1:0]      top_idx;
  logic                              top;
  logic                              feedback;

  // clamp degree into 1..MAX_DEGREE
  always_comb begin
    if (cfg.poly_degree == '0) begin
      eff_degree = crcrbs_pkg::DEG_W'(1);
    end else if (cfg.poly_degree > crcrbs_pkg::DEG_W'(crcrbs_pkg::MAX_DEGREE)) begin
      eff_degree = crcrbs_pkg::DEG_W'(crcrbs_pkg::MAX_DEGREE);
    end else begin
      eff_degree = cfg.poly_degree;
    end
  end

  // width mask and masked operands
  assign mask    = crcrbs_pkg::MAX_DEGREE'(
                     ((crcrbs_pkg::MAX_DEGREE+1)'(1) << eff_degree)
                     - (crcrbs_pkg::MAX_DEGREE+1)'(1));
  assign low     = cfg.generator_low & mask;
  assign r_cur   = remainder & mask;
  assign top_idx = crcrbs_pkg::TOP_W'(eff_degree - crcrbs_pkg::DEG_W'(1));
  assign top     = r_cur[top_idx];

  // check mode shifts the bit in at the bottom, generate mode feeds it at the top
  always_comb begin
    if (cfg.crc_mode == crcrbs_pkg::MODE_CHECK) begin
      shifted  = {r_cur[crcrbs_pkg::MAX_DEGREE-2:0], data_bit} & mask;
      feedback = top;
    end else begin
      shifted  = {r_cur[crcrbs_pkg::MAX_DEGREE-2:0], 1'b0} & mask;
      feedback = top ^ data_bit;
    end
    remainder_next = feedback ? (shifted ^ low) : shifted;
  end

endmodule

// ===== rtl/crc_remainder_bit_serial.sv =====
// top level of the bit-serial crc remainder block with programmable generator
`timescale 1ns / 1ps

// Bit-serial CRC with a programmable generator of degree 1 to 32 (leading term
// implied). Frame bits arrive most significant first, one per request; a new
// bit is taken every cycle unless a last bit waits on a stalled output. Each
// bit is captured in an input register; one LFSR step from there updates the
// remainder and loads the result for a last bit. The remainder is cleared
// after each frame. In generate mode the result is the CRC of the frame padded
// with degree zeros; in check mode it is the plain remainder and the zero flag
// reports a good frame. The output register holds a result while stalled and
// input requests keep flowing until the next last bit needs that register.
// Write configuration only between frames when the block is idle.

module crc_remainder_bit_serial (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  crcrbs_pkg::in_item_t                in_data,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output crcrbs_pkg::out_item_t               out_data,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [crcrbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crcrbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  crcrbs_pkg::crc_cfg_t               cfg;
  crcrbs_pkg::in_item_t               in_reg;
  logic                               in_reg_valid;
  logic [crcrbs_pkg::MAX_DEGREE-1:0]  remainder;
  logic [crcrbs_pkg::MAX_DEGREE-1:0]  remainder_next;
  logic                               advance;
  logic                               in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.generator_low <= crcrbs_pkg::GENERATOR_LOW_RESET;
      cfg.poly_degree   <= crcrbs_pkg::POLY_DEGREE_RESET;
      cfg.crc_mode      <= crcrbs_pkg::MODE_GENERATE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        crcrbs_pkg::REG_GENERATOR_LOW: cfg.generator_low <= cfg_data;
        crcrbs_pkg::REG_POLY_DEGREE:   cfg.poly_degree   <= cfg_data[crcrbs_pkg::DEG_W-1:0];
        crcrbs_pkg::REG_CRC_MODE:      cfg.crc_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a bit moves on unless it ends a frame and the output register is blocked
  assign advance  = in_reg_valid && (!in_reg.frame_last || !out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  // lfsr step
  crcrbs_step u_step (
    .cfg            (cfg),
    .remainder      (remainder),
    .data_bit       (in_reg.data_bit),
    .remainder_next (remainder_next)
  );

  // remainder register, cleared at the end of each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (advance) begin
      remainder <= in_reg.frame_last ? '0 : remainder_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_reg.frame_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg.frame_last) begin
      out_data.remainder_value   <= remainder_next;
      out_data.remainder_is_zero <= (remainder_next == '0);
    end
  end

endmodule

// ===== rtl/crcrbs_checker.sv =====
// port-level checker for the bit-serial crc remainder block and its bind
`timescale 1ns / 1ps

module crcrbs_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input crcrbs_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input crcrbs_pkg::out_item_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // zero flag matches the remainder
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.remainder_is_zero == (out_data.remainder_value == '0))
    else $error("zero flag disagrees with remainder");

  // a fresh result must follow an accepted last-bit request
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.frame_last, 2))
    else $error("result without a preceding last bit");

endmodule

bind crc_remainder_bit_serial crcrbs_checker u_crcrbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/crc_remainder_bit_serial_tb.sv =====
// testbench for the bit-serial crc remainder block: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module crc_remainder_bit_serial_tb;

  localparam logic [crcrbs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL   = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;

  // tracks the remainder register and the frames still owed a result
  class remainder_scoreboard;
    logic [31:0]           gen_low;
    logic [5:0]            degree;
    logic                  mode;
    logic [63:0]           remainder;
    crcrbs_pkg::out_item_t expected_remainders[$];
    int                    errors;
    int                    results_seen;

    function new();
      gen_low      = crcrbs_pkg::GENERATOR_LOW_RESET;
      degree       = crcrbs_pkg::POLY_DEGREE_RESET;
      mode         = crcrbs_pkg::MODE_GENERATE;
      remainder    = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    static function int clamp_degree(logic [5:0] deg);
      if (deg < 1) return 1;
      if (deg > crcrbs_pkg::MAX_DEGREE) return crcrbs_pkg::MAX_DEGREE;
      return int'(deg);
    endfunction

    function int pending();
      return expected_remainders.size();
    endfunction

    function void write_reg(logic [crcrbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        crcrbs_pkg::REG_GENERATOR_LOW: gen_low = data;
        crcrbs_pkg::REG_POLY_DEGREE:   degree = data[5:0];
        crcrbs_pkg::REG_CRC_MODE:      mode = data[0];
        default: ;
      endcase
    endfunction

    // one lfsr step per accepted bit; a last bit closes the frame
    function void note_request(crcrbs_pkg::in_item_t req);
      int                    d;
      logic [63:0]           mask;
      logic [63:0]           low;
      logic [63:0]           r;
      logic                  top;
      crcrbs_pkg::out_item_t due;
      d    = clamp_degree(degree);
      mask = (64'd1 << d) - 64'd1;
      low  = {32'd0, gen_low} & mask;
      r    = remainder & mask;
      top  = r[d-1];
      if (mode == crcrbs_pkg::MODE_CHECK) begin
        r = ((r << 1) | {63'd0, req.data_bit}) & mask;
        if (top) r = r ^ low;
      end else begin
        r = (r << 1) & mask;
        if (top ^ req.data_bit) r = r ^ low;
      end
      remainder = r;
      if (req.frame_last) begin
        due.remainder_value   = r[31:0];
        due.remainder_is_zero = (r == 64'd0);
        expected_remainders   = {expected_remainders, due};
        remainder = '0;
      end
    endfunction

    task report(string msg);
      $display("[%0t] error: %s", $time, msg);
      errors++;
    endtask

    task check_result(crcrbs_pkg::out_item_t got);
      crcrbs_pkg::out_item_t due;
      if (expected_remainders.size() == 0) begin
        report($sformatf("remainder %h with no frame pending", got.remainder_value));
        return;
      end
      due = expected_remainders.pop_front();
      results_seen++;
      if (got.remainder_value !== due.remainder_value)
        report($sformatf("remainder %h, predicted %h", got.remainder_value,
                         due.remainder_value));
      if (got.remainder_is_zero !== due.remainder_is_zero)
        report($sformatf("zero flag %b, predicted %b", got.remainder_is_zero,
                         due.remainder_is_zero));
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  crcrbs_pkg::in_item_t               in_data;
  logic                               out_valid;
  logic                               out_stall;
  crcrbs_pkg::out_item_t              out_data;
  logic                               cfg_wr_en;
  logic [crcrbs_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [crcrbs_pkg::CFG_DATA_W-1:0]  cfg_data;

  remainder_scoreboard sb;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_long = 1'b0;
  int items_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;

  crc_remainder_bit_serial dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watch both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // offer one bit, with an optional idle burst ahead of it
  task automatic send_request(input crcrbs_pkg::in_item_t req);
    int gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // bits[len-1] goes first; close marks the final bit as last
  task automatic send_frame(input logic [63:0] bits, input int len, input bit close);
    crcrbs_pkg::in_item_t req;
    for (int i = len - 1; i >= 0; i--) begin
      req.data_bit   = bits[i];
      req.frame_last = close && (i == 0);
      send_request(req);
    end
    if (close) frames_sent++;
  endtask

  // stop offering, wait out pending results and the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [crcrbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_crc(input logic [31:0] gen, input logic [5:0] deg,
                             input logic mode, input bit poke_unused);
    drain();
    write_reg(crcrbs_pkg::REG_GENERATOR_LOW, gen);
    write_reg(crcrbs_pkg::REG_POLY_DEGREE, {26'd0, deg});
    write_reg(crcrbs_pkg::REG_CRC_MODE, {31'd0, mode});
    if (poke_unused) write_reg(REG_UNUSED, $urandom());
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // carry-less product of a message and the generator: a valid codeword
  function automatic logic [63:0] codeword(logic [63:0] msg, int mlen);
    int          d;
    logic [63:0] g;
    logic [63:0] acc;
    d   = remainder_scoreboard::clamp_degree(sb.degree);
    g   = (64'd1 << d) | ({32'd0, sb.gen_low} & ((64'd1 << d) - 64'd1));
    acc = '0;
    for (int i = 0; i < mlen; i++)
      if (msg[i]) acc = acc ^ (g << i);
    return acc;
  endfunction

  initial begin
    int          start;
    int          nframes;
    int          mlen;
    int          len;
    logic [5:0]  deg;
    logic [31:0] gen;
    logic        mode;
    logic [63:0] bits;
    bit          pressure_done;
    sb            = new();
    pressure_done = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= crcrbs_pkg::REG_GENERATOR_LOW;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, one-bit frames of each value
    send_frame(64'd1, 1, 1'b1);
    send_frame(64'd0, 1, 1'b1);
    // full width check mode, plus a write to an index past the list
    program_crc(32'h04C1_1DB7, 6'd32, crcrbs_pkg::MODE_CHECK, 1'b1);
    send_frame(64'hF, 4, 1'b1);
    // degree zero acts as degree one, zero flag in generate mode
    program_crc(32'hFFFF_FFFF, 6'd0, crcrbs_pkg::MODE_GENERATE, 1'b0);
    send_frame(64'd0, 1, 1'b1);
    send_frame(64'd1, 1, 1'b1);
    // degree above the maximum is clamped
    program_crc(32'hFFFF_FFFF, 6'd63, crcrbs_pkg::MODE_CHECK, 1'b0);
    send_frame(64'b101, 3, 1'b1);
    // generator bits above the degree are ignored; frame equal to generator
    program_crc(32'hFFFF_FFE5, 6'd5, crcrbs_pkg::MODE_CHECK, 1'b0);
    send_frame(64'b100101, 6, 1'b1);
    // settings change in the middle of a frame
    program_crc(32'h0000_0007, 6'd8, crcrbs_pkg::MODE_GENERATE, 1'b0);
    send_frame(64'b10, 2, 1'b0);
    program_crc(32'h0000_0003, 6'd4, crcrbs_pkg::MODE_CHECK, 1'b0);
    send_frame(64'd1, 1, 1'b1);

    // random phases: new settings, a few frames, sometimes an open frame
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (!pressure_done && items_sent - start >= 350) begin
        // receiver holds off while short frames keep coming
        drain();
        send_idle = 1'b0;
        hold_long = 1'b1;
        for (int i = 0; i < 50; i++) send_frame({63'd0, 1'(i)}, 1, 1'b1);
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:       deg = 6'd0;
        1:       deg = 6'd1;
        2:       deg = 6'd32;
        3:       deg = 6'($urandom_range(33, 63));
        default: deg = 6'($urandom_range(2, 31));
      endcase
      case ($urandom_range(0, 7))
        0:       gen = 32'd0;
        1:       gen = 32'hFFFF_FFFF;
        default: gen = $urandom();
      endcase
      mode = $urandom_range(0, 1) ? crcrbs_pkg::MODE_CHECK : crcrbs_pkg::MODE_GENERATE;
      program_crc(gen, deg, mode, $urandom_range(0, 5) == 0);
      if (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      nframes = $urandom_range(2, 8);
      for (int f = 0; f < nframes; f++) begin
        if (mode == crcrbs_pkg::MODE_CHECK && $urandom_range(0, 1)) begin
          mlen = $urandom_range(1, 24);
          len  = mlen + remainder_scoreboard::clamp_degree(deg);
          bits = codeword({$urandom(), $urandom()} & ((64'd1 << mlen) - 64'd1), mlen);
          // occasionally corrupt one bit
          if ($urandom_range(0, 2) == 0) bits[$urandom_range(0, len - 1)] ^= 1'b1;
        end else begin
          len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          bits = {$urandom(), $urandom()};
        end
        send_frame(bits, len, 1'b1);
      end
      if ($urandom_range(0, 3) == 0)
        send_frame({$urandom(), $urandom()}, $urandom_range(1, 10), 1'b0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d bits in %0d frames under %0d register settings", items_sent,
             frames_sent, settings_used);
    $display("%0d remainders compared, %0d errors", sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("crc_remainder_bit_serial: match");
    end else begin
      $display("crc_remainder_bit_serial: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("timeout waiting for the block");
    $display("crc_remainder_bit_serial: mismatch");
    $finish;
  end

endmodule

// ===== crc_remainder_bit_serial.f =====
rtl/crcrbs_pkg.sv
rtl/crcrbs_step.sv
rtl/crc_remainder_bit_serial.sv
rtl/crcrbs_checker.sv
tb/crc_remainder_bit_serial_tb.sv
